### sv/fpmd_pkg.sv
// shared types, constants and helpers for the fixed-point multiply/divide unit
`default_nettype none

package fpmd_pkg;

    // operand and result word width
    localparam int WORD_W = 32;
    // default number of fraction bits
    localparam int FRAC_BITS_DEF = 16;
    // width of the long-division bit counter
    localparam int CNT_W = $clog2(WORD_W);

    // operation select codes
    localparam logic ACT_MUL = 1'b0;
    localparam logic ACT_DIV = 1'b1;

    // input transaction
    typedef struct packed {
        logic                     action;
        logic signed [WORD_W-1:0] operand_a;
        logic signed [WORD_W-1:0] operand_b;
    } fpmd_in_t;

    // output transaction
    typedef struct packed {
        logic signed [WORD_W-1:0] result;
        logic                     divide_by_zero;
    } fpmd_out_t;

    // start request to the divide sequencer
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    // completion from the divide sequencer
    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
    } div_rsp_t;

    // divide sequencer states
    typedef enum logic [2:0] {
        DIV_IDLE,
        DIV_OUTER,
        DIV_INNER,
        DIV_LONG,
        DIV_SUB,
        DIV_FIX,
        DIV_DONE
    } div_state_t;

    // unsigned magnitude of a two's complement word, most negative maps to 2^31
    function automatic logic [WORD_W-1:0] mag_word(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] m;
        m = v[WORD_W-1] ? (WORD_W'(0) - v) : v;
        return m;
    endfunction

endpackage

`default_nettype wire

### sv/fpmd_divider.sv
// iterative divide sequencer around one shared subtract/compare unit
`default_nettype none

module fpmd_divider #(
    parameter int FRAC_BITS = fpmd_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fpmd_pkg::div_req_t req,
    output fpmd_pkg::div_rsp_t rsp
);
    import fpmd_pkg::*;

    localparam int STEP_W = $clog2(FRAC_BITS + 1);
    localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(FRAC_BITS);

    div_state_t        state_reg, state_next;
    logic [WORD_W-1:0] num_reg, num_next;
    logic [WORD_W-1:0] den_reg, den_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic [CNT_W-1:0]  bit_reg, bit_next;
    logic              neg_reg, neg_next;

    logic [WORD_W:0]   sub_a;
    logic [WORD_W+1:0] sub_diff;
    logic              sub_borrow;
    logic              num_zero;
    logic              steps_done;
    logic              long_qbit;
    logic [WORD_W-1:0] long_rem;
    logic [WORD_W-1:0] long_quo;

    // shared subtractor: borrow means den is above the selected operand
    assign sub_a      = (state_reg == DIV_LONG) ? {rem_reg, num_reg[WORD_W-1]}
                                                : {1'b0, num_reg};
    assign sub_diff   = {1'b0, sub_a} - {2'b00, den_reg};
    assign sub_borrow = sub_diff[WORD_W+1];
    assign num_zero   = (num_reg == '0);
    assign steps_done = (steps_reg == STEP_MAX);

    // long division bit step
    assign long_qbit = ~sub_borrow;
    assign long_rem  = sub_borrow ? sub_a[WORD_W-1:0] : sub_diff[WORD_W-1:0];
    assign long_quo  = {num_reg[WORD_W-2:0], long_qbit};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (req.start)
                begin
                    state_next = DIV_OUTER;
                end
            end
            DIV_OUTER:
            begin
                if (num_zero || steps_done)
                begin
                    state_next = DIV_FIX;
                end
                else if (sub_borrow)
                begin
                    state_next = DIV_INNER;
                end
                else if (steps_reg == '0)
                begin
                    state_next = DIV_LONG;
                end
                else
                begin
                    state_next = DIV_SUB;
                end
            end
            DIV_INNER:
            begin
                if (!(sub_borrow && !steps_done))
                begin
                    state_next = DIV_SUB;
                end
            end
            DIV_LONG:
            begin
                if (bit_reg == '0)
                begin
                    state_next = DIV_OUTER;
                end
            end
            DIV_SUB:
            begin
                if (sub_borrow)
                begin
                    state_next = DIV_OUTER;
                end
            end
            DIV_FIX:
            begin
                if (steps_done)
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                state_next = DIV_IDLE;
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    // datapath updates per state
    always_comb
    begin
        num_next   = num_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        steps_next = steps_reg;
        bit_next   = bit_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (req.start)
                begin
                    num_next   = mag_word(req.dividend);
                    den_next   = mag_word(req.divisor);
                    quo_next   = '0;
                    steps_next = '0;
                    neg_next   = req.dividend[WORD_W-1] ^ req.divisor[WORD_W-1];
                end
            end
            DIV_OUTER:
            begin
                // prime the long division in case it runs next
                rem_next = '0;
                bit_next = '1;
            end
            DIV_INNER:
            begin
                // scale numerator up, or divisor down once numerator is full
                if (sub_borrow && !steps_done)
                begin
                    if (num_reg[WORD_W-1])
                    begin
                        den_next = den_reg >> 1;
                    end
                    else
                    begin
                        num_next = num_reg << 1;
                    end
                    quo_next   = quo_reg << 1;
                    steps_next = steps_reg + STEP_W'(1);
                end
            end
            DIV_LONG:
            begin
                // one quotient bit per cycle, quotient shifts into num
                rem_next = long_rem;
                num_next = long_quo;
                bit_next = bit_reg - CNT_W'(1);
                if (bit_reg == '0)
                begin
                    quo_next = quo_reg + long_quo;
                    num_next = long_rem;
                end
            end
            DIV_SUB:
            begin
                // small partial quotient by repeated subtraction
                if (!sub_borrow)
                begin
                    num_next = sub_diff[WORD_W-1:0];
                    quo_next = quo_reg + WORD_W'(1);
                end
            end
            DIV_FIX:
            begin
                // align the quotient for the unused shift steps
                if (!steps_done)
                begin
                    quo_next   = quo_reg << 1;
                    steps_next = steps_reg + STEP_W'(1);
                end
            end
            DIV_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // completion output
    always_comb
    begin
        rsp.done     = (state_reg == DIV_DONE);
        rsp.quotient = neg_reg ? (WORD_W'(0) - quo_reg) : quo_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        den_reg   <= den_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        steps_reg <= steps_next;
        bit_reg   <= bit_next;
        neg_reg   <= neg_next;
    end

endmodule

`default_nettype wire

### sv/fixed_point_mul_div_unit_core.sv
// Signed fixed-point multiply/divide unit, top level.
// Multiply: product captured into a holding register, then passed to the output register;
// a new command is taken only once the holding register has moved on.
// Divide: sequenced on one shared 33-bit subtractor: a long division at most once, then
// one shift or subtract per cycle.
// Zero divisor answers like a multiply. Reset clears control state only.
`default_nettype none

module fixed_point_mul_div_unit_core #(
    parameter int FRAC_BITS = fpmd_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  fpmd_pkg::fpmd_in_t cmd,
    output logic               res_valid,
    input  logic               res_stall,
    output fpmd_pkg::fpmd_out_t res
);
    import fpmd_pkg::*;

    logic                       cmd_accept;
    logic                       is_div;
    logic                       div_zero;
    logic signed [2*WORD_W-1:0] prod;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    logic      busy_reg;
    logic      pend_valid_reg;
    fpmd_out_t pend_reg;
    logic      res_valid_reg;
    fpmd_out_t res_reg;
    logic      pend_move;

    assign cmd_stall  = busy_reg | pend_valid_reg;
    assign cmd_accept = cmd_valid & ~cmd_stall;
    assign is_div     = (cmd.action == ACT_DIV);
    assign div_zero   = (cmd.operand_b == '0);

    // full signed product, fraction bits dropped at capture
    assign prod = $signed(cmd.operand_a) * $signed(cmd.operand_b);

    // divide request
    always_comb
    begin
        div_req.start    = cmd_accept & is_div & ~div_zero;
        div_req.dividend = cmd.operand_a;
        div_req.divisor  = cmd.operand_b;
    end

    fpmd_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // holding register moves to the output stage when it is free
    assign pend_move = pend_valid_reg & (~res_valid_reg | ~res_stall);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (div_req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (div_rsp.done)
            begin
                busy_reg <= 1'b0;
            end

            if ((cmd_accept && !div_req.start) || div_rsp.done)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_move)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (pend_move)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd_accept && !div_req.start)
        begin
            if (is_div)
            begin
                pend_reg.result         <= '0;
                pend_reg.divide_by_zero <= 1'b1;
            end
            else
            begin
                pend_reg.result         <= prod[FRAC_BITS +: WORD_W];
                pend_reg.divide_by_zero <= 1'b0;
            end
        end
        else if (div_rsp.done)
        begin
            pend_reg.result         <= div_rsp.quotient;
            pend_reg.divide_by_zero <= 1'b0;
        end

        if (pend_move)
        begin
            res_reg <= pend_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire
